[rtl/assert_macros.svh]
// Assertion macros shared by the frame unpacker RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies expectation in the same cycle.
`define SFU_ASSERT_IMP(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Condition implies expectation in the following cycle.
`define SFU_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

[rtl/sfu_pkg.sv]
// Shared types and constants for the serial frame unpacker.
// No dependencies; used by every module of the block except sfu_ram.
`timescale 1ns / 1ps

package sfu_pkg;

	localparam int BYTE_W          = 8;
	localparam int BYTE_IDX_W      = 6;
	localparam int SUM_W           = 16;
	localparam int FRAME_BYTES_DEF = 64;
	localparam int NUM_BANKS       = 2;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

	// Register index of the header byte, taken from paddr[2].
	localparam logic REG_HEADER = 1'b0;

	// Descriptor of one verified frame waiting to be sent.
	typedef struct packed {
		logic                  bank;
		logic [BYTE_IDX_W-1:0] len;
	} desc_t;

endpackage

[rtl/sfu_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and read port; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sfu_front.sv]
// Front end: hunts for the header, checks the length, stores the frame and its sum.
// Depends on sfu_pkg; writes frame bytes into the frame RAM, pushes descriptors.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfu_front #(
	parameter int FRAME_BYTES = sfu_pkg::FRAME_BYTES_DEF,
	parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_accept,
	input  logic [sfu_pkg::BYTE_W-1:0] in_byte,
	input  logic [sfu_pkg::BYTE_W-1:0] header_value,
	output logic                      ram_we,
	output logic [IDX_W:0]            ram_waddr,
	output logic [sfu_pkg::BYTE_W-1:0] ram_wdata,
	output logic                      push,
	output sfu_pkg::desc_t            push_desc
);

	import sfu_pkg::*;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_LEN,
		ST_BODY
	} state_t;

	localparam logic [BYTE_W-1:0] LEN_LIMIT = BYTE_W'(FRAME_BYTES - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  len_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BYTE_W-1:0] hi_q;
	logic              bank_q;

	logic hdr_hit;
	logic len_ok;
	logic final_byte;
	logic sum_ok;

	// Byte classification.
	always_comb begin
		hdr_hit    = (in_byte == header_value);
		len_ok     = (in_byte != '0) && (in_byte < LEN_LIMIT);
		final_byte = (fill_q == len_q + IDX_W'(1));
		sum_ok     = (sum_q == {hi_q, in_byte});
	end

	// Frame RAM write: header at index 0, all other bytes at the fill index.
	always_comb begin
		ram_wdata = in_byte;
		ram_waddr = {bank_q, (state_q == ST_HUNT) ? IDX_W'(0) : fill_q};
		case (state_q)
			ST_HUNT: ram_we = in_accept && hdr_hit;
			ST_LEN:  ram_we = in_accept && len_ok;
			ST_BODY: ram_we = in_accept;
			default: ram_we = 1'b0;
		endcase
	end

	// A frame whose final byte matches the sum is handed to the back end.
	assign push           = in_accept && (state_q == ST_BODY) && final_byte && sum_ok;
	assign push_desc.bank = bank_q;
	assign push_desc.len  = BYTE_IDX_W'(len_q);

	// Parser state, fill index, running sum and checksum high byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			fill_q  <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			hi_q    <= '0;
			bank_q  <= 1'b0;
		end else if (in_accept) begin
			case (state_q)
				ST_HUNT: begin
					if (hdr_hit) begin
						state_q <= ST_LEN;
						fill_q  <= IDX_W'(1);
						sum_q   <= '0;
					end
				end
				ST_LEN: begin
					if (len_ok) begin
						state_q <= ST_BODY;
						len_q   <= in_byte[IDX_W-1:0];
						fill_q  <= IDX_W'(2);
						// The length byte sits at index 1 and is summed unless L is one.
						sum_q   <= (in_byte > BYTE_W'(1)) ? SUM_W'(in_byte) : '0;
						hi_q    <= in_byte;
					end else begin
						state_q <= ST_HUNT;
					end
				end
				ST_BODY: begin
					if (final_byte) begin
						state_q <= ST_HUNT;
						if (sum_ok) begin
							bank_q <= ~bank_q;
						end
					end else begin
						fill_q <= fill_q + IDX_W'(1);
						if (fill_q < len_q) begin
							sum_q <= sum_q + SUM_W'(in_byte);
						end
						if (fill_q == len_q) begin
							hi_q <= in_byte;
						end
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	// The fill index never runs past the final checksum byte.
	`SFU_ASSERT_IMP(a_fill_bound, state_q == ST_BODY, fill_q <= len_q + IDX_W'(1), "fill index past frame end")

endmodule

[rtl/sfu_desc_fifo.sv]
// Two-entry queue of frame descriptors between the front and back ends.
// Depends on sfu_pkg for the descriptor type.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfu_desc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfu_pkg::desc_t push_desc,
	input  logic           pop,
	output sfu_pkg::desc_t head,
	output logic           not_empty,
	output logic           full
);

	import sfu_pkg::*;

	localparam int CNT_W = $clog2(NUM_BANKS + 1);
	localparam int PTR_W = $clog2(NUM_BANKS);

	desc_t            slot_q [NUM_BANKS];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(NUM_BANKS));

	// Descriptor storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`SFU_ASSERT_IMP(a_push_room, push, !full, "descriptor pushed into a full queue")
	`SFU_ASSERT_IMP(a_pop_data, pop, not_empty, "descriptor popped from an empty queue")

endmodule

[rtl/sfu_back.sv]
// Back end: reads verified frames from the frame RAM and sends them byte by byte.
// Depends on sfu_pkg; takes descriptors from sfu_desc_fifo.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfu_back #(
	parameter int FRAME_BYTES = sfu_pkg::FRAME_BYTES_DEF,
	parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfu_pkg::desc_t                head,
	input  logic                          not_empty,
	output logic                          pop,
	output logic                          ram_re,
	output logic [IDX_W:0]                ram_raddr,
	input  logic [sfu_pkg::BYTE_W-1:0]     ram_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sfu_pkg::BYTE_W-1:0]     frame_byte,
	output logic [sfu_pkg::BYTE_IDX_W-1:0] byte_index,
	output logic                          last_byte
);

	import sfu_pkg::*;

	logic [BYTE_IDX_W-1:0] cnt_q;
	logic                  rd_valid_s1;
	logic [BYTE_IDX_W-1:0] idx_s1;
	logic                  last_s1;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     frame_byte_q;
	logic [BYTE_IDX_W-1:0] byte_index_q;
	logic                  last_byte_q;

	logic move;
	logic issue;
	logic last_issue;

	// Read data moves to the output register when it is empty or being taken;
	// a new read is issued only when the RAM data register will be free.
	always_comb begin
		move       = rd_valid_s1 && (!out_valid_q || !out_stall);
		issue      = not_empty && (!rd_valid_s1 || move);
		last_issue = (cnt_q == head.len + BYTE_IDX_W'(1));
	end

	assign ram_re    = issue;
	assign ram_raddr = {head.bank, cnt_q[IDX_W-1:0]};
	assign pop       = issue && last_issue;

	// Read issue counter and the RAM read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			idx_s1      <= '0;
			last_s1     <= 1'b0;
		end else begin
			rd_valid_s1 <= issue || (rd_valid_s1 && !move);
			if (issue) begin
				idx_s1  <= cnt_q;
				last_s1 <= last_issue;
				cnt_q   <= last_issue ? '0 : cnt_q + BYTE_IDX_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			frame_byte_q <= '0;
			byte_index_q <= '0;
			last_byte_q  <= 1'b0;
		end else if (move) begin
			out_valid_q  <= 1'b1;
			frame_byte_q <= ram_rdata;
			byte_index_q <= idx_s1;
			last_byte_q  <= last_s1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign byte_index = byte_index_q;
	assign last_byte  = last_byte_q;

	// Read data that cannot move must stay in the RAM data register.
	`SFU_ASSERT_NEXT(a_hold_read, rd_valid_s1 && !move, rd_valid_s1, "pending read data dropped")

endmodule

[rtl/serial_frame_unpacker_sum16.sv]
// Serial frame unpacker with a 16-bit additive checksum.
// Channels: input bytes on in_valid/in_stall/rx_byte; verified frame bytes on
// out_valid/out_stall with frame_byte, byte_index and last_byte. A transfer
// happens on a rising edge with valid high and stall low.
// The parser waits for header_value, takes a length byte L with 0 < L < FRAME_BYTES-1,
// then L more bytes; the 16-bit sum of bytes 1..L-1 must equal bytes L,L+1
// (big-endian). Good frames are sent whole (L+2 bytes, last one marked); bad
// frames vanish without output.
// Throughput: one input byte per cycle while a frame buffer is free; the front
// end parses on the fly. Frames sit in two RAM banks; input stalls while both
// hold frames, until the last byte of the older one is read from the RAM.
// Output runs at one byte per cycle while out_stall is low, limited by the single RAM read port.
// With no earlier frame waiting, the first byte of a good frame follows the transfer of
// its final checksum byte through the descriptor queue, RAM read register and output register.
// Reset: parser hunts, header_value is 0xAA, no frames queued. A stalled output
// holds its byte; stalls back up into the queue and then into the input.
// Config: APB register 0 (header_value); the user writes it only while the block is idle (not enforced).
`timescale 1ns / 1ps

module serial_frame_unpacker_sum16 #(
	parameter int FRAME_BYTES = sfu_pkg::FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sfu_pkg::PADDR_W-1:0]    paddr,
	input  logic [sfu_pkg::PDATA_W-1:0]    pwdata,
	output logic [sfu_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sfu_pkg::BYTE_W-1:0]      rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sfu_pkg::BYTE_W-1:0]      frame_byte,
	output logic [sfu_pkg::BYTE_IDX_W-1:0]  byte_index,
	output logic                           last_byte
);

	import sfu_pkg::*;

	localparam int IDX_W = $clog2(FRAME_BYTES);
	localparam int RAM_DEPTH = NUM_BANKS << IDX_W;

	logic [BYTE_W-1:0] header_q;
	logic              cfg_wr;
	logic              in_accept;

	logic              ram_we;
	logic [IDX_W:0]    ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W:0]    ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	logic  push;
	desc_t push_desc;
	logic  pop;
	desc_t head;
	logic  not_empty;
	logic  full;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEADER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_wr) begin
			header_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_HEADER) ? PDATA_W'(header_q) : '0;

	// Input transfers are held off while both frame banks are taken.
	assign in_stall  = full;
	assign in_accept = in_valid && !full;

	sfu_front #(
		.FRAME_BYTES(FRAME_BYTES),
		.IDX_W      (IDX_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.in_byte     (rx_byte),
		.header_value(header_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.push        (push),
		.push_desc   (push_desc)
	);

	sfu_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sfu_desc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(push_desc),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.full     (full)
	);

	sfu_back #(
		.FRAME_BYTES(FRAME_BYTES),
		.IDX_W      (IDX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_byte(frame_byte),
		.byte_index(byte_index),
		.last_byte (last_byte)
	);

endmodule
